// ===== rtl/core/tfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants for the tpkt frame delineator
// Phase codes, byte class codes and header constants.
// ----------------------------------------------------------------------------
package tfd_pkg;

   // header constants
   localparam logic [7:0]  TPKT_VERSION    = 8'h03;
   localparam logic [7:0]  TPKT_RESERVED   = 8'h00;
   localparam logic [15:0] TPKT_HEADER_LEN = 16'd4;
   localparam logic [15:0] MAX_LEN_RESET   = 16'd8192;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int CLASS_W = 2;

   // delineation phase
   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_HUNT    = 3'd1,
      PH_RESV    = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_LEN_LO  = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   // byte classification
   typedef enum logic [CLASS_W-1:0] {
      CLS_DISCARD = 2'd0,
      CLS_HEADER  = 2'd1,
      CLS_PAYLOAD = 2'd2,
      CLS_REJECT  = 2'd3
   } byte_class_type;

endpackage

// ===== rtl/core/tpkt_frame_delineator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpkt_frame_delineator: byte-wise tpkt frame delineation
// Classifies each received byte as hunt discard, header, payload or rejected
// header, and marks the length and the final byte of each accepted frame.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_in_byte
//   rsp      out        rsp_valid/stall    out_byte, byte_class,
//                                          frame_length, frame_last
//   csr      in         csr_wr_en          csr_wr_data (max_frame_length)
//
// One item per cycle unless the result side stalls: each byte is classified
// in the cycle it is accepted and its result appears from the output register
// on the next cycle. The output register frees in the cycle it is taken, so
// the rate is set only by the phase/counter update.
// req_stall is high only while a result waits and rsp_stall is high.
// Reset is synchronous: phase returns to expect start of frame and the
// maximum length register to 8192.
// ----------------------------------------------------------------------------
module tpkt_frame_delineator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tfd_pkg::BYTE_W-1:0]      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tfd_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic [tfd_pkg::CLASS_W-1:0]     rsp_byte_class,
   output logic [tfd_pkg::LEN_W-1:0]       rsp_frame_length,
   output logic                            rsp_frame_last,
   input  logic                            csr_wr_en,
   input  logic [tfd_pkg::LEN_W-1:0]       csr_wr_data
);
   import tfd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [BYTE_W-1:0]     length_high_ff, length_high_in;
   logic [LEN_W-1:0]      bytes_left_ff, bytes_left_in;
   logic                  candidate_ff, candidate_in;
   logic [LEN_W-1:0]      max_len_ff;

   logic                  rsp_valid_ff;
   logic [BYTE_W-1:0]     out_byte_ff;
   byte_class_type        class_ff, class_in;
   logic [LEN_W-1:0]      flen_ff, flen_in;
   logic                  last_ff, last_in;

   logic                  accept;
   logic                  out_free;
   logic [LEN_W-1:0]      len_word;

   // handshake: output register frees when empty or taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign accept    = req_valid && out_free;

   assign len_word = {length_high_ff, req_in_byte};

   // maximum length register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // next phase and classification of the incoming item
   always_comb begin
      phase_in       = phase_ff;
      length_high_in = length_high_ff;
      bytes_left_in  = bytes_left_ff;
      candidate_in   = candidate_ff;
      class_in       = CLS_DISCARD;
      flen_in        = '0;
      last_in        = 1'b0;
      unique case (phase_ff)
         PH_START: begin
            if (req_in_byte == TPKT_VERSION) begin
               class_in = CLS_HEADER;
               phase_in = PH_RESV;
            end else begin
               phase_in     = PH_HUNT;
               candidate_in = 1'b0;
            end
         end
         PH_RESV: begin
            class_in = CLS_HEADER;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            class_in       = CLS_HEADER;
            length_high_in = req_in_byte;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            flen_in = len_word;
            if (len_word < TPKT_HEADER_LEN || len_word > max_len_ff) begin
               // rejected header: only the last byte may start a new hunt pair
               class_in     = CLS_REJECT;
               phase_in     = PH_HUNT;
               candidate_in = (req_in_byte == TPKT_VERSION);
            end else begin
               class_in = CLS_HEADER;
               if (len_word == TPKT_HEADER_LEN) begin
                  last_in       = 1'b1;
                  phase_in      = PH_START;
                  bytes_left_in = '0;
               end else begin
                  bytes_left_in = len_word - TPKT_HEADER_LEN;
                  phase_in      = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            class_in = CLS_PAYLOAD;
            if (bytes_left_ff <= LEN_W'(1)) begin
               bytes_left_in = '0;
               last_in       = 1'b1;
               phase_in      = PH_START;
            end else begin
               bytes_left_in = bytes_left_ff - LEN_W'(1);
            end
         end
         default: begin
            // hunt, also for unused phase codes
            if (candidate_ff && req_in_byte == TPKT_RESERVED) begin
               class_in     = CLS_HEADER;
               candidate_in = 1'b0;
               phase_in     = PH_LEN_HI;
            end else begin
               candidate_in = (req_in_byte == TPKT_VERSION);
               phase_in     = PH_HUNT;
            end
         end
      endcase
   end

   // delineation state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         length_high_ff <= '0;
         bytes_left_ff  <= '0;
         candidate_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         length_high_ff <= length_high_in;
         bytes_left_ff  <= bytes_left_in;
         candidate_ff   <= candidate_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         out_byte_ff <= req_in_byte;
         class_ff    <= class_in;
         flen_ff     <= flen_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_byte_class   = class_ff;
   assign rsp_frame_length = flen_ff;
   assign rsp_frame_last   = last_ff;

   // checks on the delineation logic
   a_last_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> (class_ff == CLS_HEADER || class_ff == CLS_PAYLOAD))
      else $error("frame end marked outside an accepted frame");

   a_len_on_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && flen_ff != '0 |-> (class_ff == CLS_HEADER || class_ff == CLS_REJECT))
      else $error("frame length shown on a non-header item");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> bytes_left_ff != '0)
      else $error("payload phase with no bytes left");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_PAYLOAD && bytes_left_ff > LEN_W'(1)
      |=> bytes_left_ff == $past(bytes_left_ff) - LEN_W'(1))
      else $error("payload counter did not step down");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(bytes_left_ff))
      else $error("state changed without an accepted item");

endmodule

// ===== sim/tfd_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_frame_checker: scoreboard for the tpkt frame delineator
// Watches the byte channel, the result channel and the length register
// writes. Each accepted byte is classified by an independent model of the
// delineation phases. Each accepted result is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tfd_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [tfd_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [tfd_pkg::BYTE_W-1:0]      rsp_out_byte,
   input  logic [tfd_pkg::CLASS_W-1:0]     rsp_byte_class,
   input  logic [tfd_pkg::LEN_W-1:0]       rsp_frame_length,
   input  logic                            rsp_frame_last,
   input  logic                            csr_wr_en,
   input  logic [tfd_pkg::LEN_W-1:0]       csr_wr_data,
   output int                              error_count,
   output int                              outstanding
);
   import tfd_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      byte_class_type    cls;
      logic [LEN_W-1:0]  len;
      logic              last;
   } byte_result_type;

   // model state
   logic [LEN_W-1:0]  max_len;
   phase_type         phase;
   logic [BYTE_W-1:0] len_high;
   logic [LEN_W-1:0]  bytes_left;
   logic              candidate;

   byte_result_type predicted_bytes [$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // classify one byte and advance the delineation state
   function automatic byte_result_type classify_byte(input logic [BYTE_W-1:0] b);
      byte_result_type  r;
      logic [LEN_W-1:0] hdr_len;
      r.data  = b;
      r.cls   = CLS_DISCARD;
      r.len   = '0;
      r.last  = 1'b0;
      hdr_len = {len_high, b};
      case (phase)
         PH_START: begin
            if (b == TPKT_VERSION) begin
               r.cls = CLS_HEADER;
               phase = PH_RESV;
            end else begin
               phase     = PH_HUNT;
               candidate = 1'b0;
            end
         end
         PH_RESV: begin
            r.cls = CLS_HEADER;
            phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            r.cls    = CLS_HEADER;
            len_high = b;
            phase    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            r.len = hdr_len;
            if (hdr_len < TPKT_HEADER_LEN || hdr_len > max_len) begin
               // rejected header: only its last byte may start a new pair
               r.cls     = CLS_REJECT;
               phase     = PH_HUNT;
               candidate = (b == TPKT_VERSION);
            end else begin
               r.cls = CLS_HEADER;
               if (hdr_len == TPKT_HEADER_LEN) begin
                  r.last     = 1'b1;
                  phase      = PH_START;
                  bytes_left = '0;
               end else begin
                  bytes_left = hdr_len - TPKT_HEADER_LEN;
                  phase      = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            r.cls = CLS_PAYLOAD;
            if (bytes_left <= LEN_W'(1)) begin
               bytes_left = '0;
               r.last     = 1'b1;
               phase      = PH_START;
            end else begin
               bytes_left = bytes_left - LEN_W'(1);
            end
         end
         default: begin
            // hunt, and any unused phase code
            if (candidate && b == TPKT_RESERVED) begin
               r.cls     = CLS_HEADER;
               candidate = 1'b0;
               phase     = PH_LEN_HI;
            end else begin
               candidate = (b == TPKT_VERSION);
               phase     = PH_HUNT;
            end
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string field, input logic [LEN_W-1:0] want,
                              input logic [LEN_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
      end
   endtask

   // compare results, then queue the prediction for the byte taken at this edge
   always @(posedge clock) begin
      byte_result_type want;
      if (reset) begin
         max_len    = MAX_LEN_RESET;
         phase      = PH_START;
         len_high   = '0;
         bytes_left = '0;
         candidate  = 1'b0;
         predicted_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_bytes.size() == 0) begin
               error_count++;
               $display("%0t: result with no byte outstanding, expected none, actual 0x%0h",
                        $time, rsp_out_byte);
            end else begin
               want = predicted_bytes.pop_front();
               check_field("out_byte", LEN_W'(want.data), LEN_W'(rsp_out_byte));
               check_field("byte_class", LEN_W'(want.cls), LEN_W'(rsp_byte_class));
               check_field("frame_length", want.len, rsp_frame_length);
               check_field("frame_last", LEN_W'(want.last), LEN_W'(rsp_frame_last));
            end
         end
         if (req_valid && !req_stall)
            predicted_bytes.push_back(classify_byte(req_in_byte));
         if (csr_wr_en)
            max_len = csr_wr_data;
      end
      outstanding = predicted_bytes.size();
   end

endmodule

// ===== sim/tb_tpkt_frame_delineator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tpkt_frame_delineator: testbench for the tpkt frame delineator
// Sends a short directed byte stream, then phases of random frames, noise
// and broken headers under several maximum frame lengths, with random gaps
// on the byte side and back-pressure on the result side. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tpkt_frame_delineator;
   import tfd_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam int CAP_LEN      = 300;

   // short frame, wrong start byte, hunt pair, odd reserved byte,
   // oversized header whose last byte is 0x03, then an undersized header
   localparam logic [7:0] DIRECTED [23] = '{
      8'h03, 8'h00, 8'h00, 8'h04,
      8'hFF,
      8'h03, 8'h00, 8'h00, 8'h05, 8'hAA,
      8'h03, 8'hFF, 8'h00, 8'h06, 8'h00, 8'hFF,
      8'h03, 8'h00, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h02
   };

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_in_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [BYTE_W-1:0]  rsp_out_byte;
   logic [CLASS_W-1:0] rsp_byte_class;
   logic [LEN_W-1:0]   rsp_frame_length;
   logic               rsp_frame_last;
   logic               csr_wr_en   = 1'b0;
   logic [LEN_W-1:0]   csr_wr_data = '0;

   int error_count;
   int outstanding;
   int cycle_count = 0;
   int sent        = 0;
   int stall_left  = 0;
   bit send_gaps   = 1'b0;
   bit stall_gaps  = 1'b0;
   bit quiet       = 1'b0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   tpkt_frame_delineator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_class   (rsp_byte_class),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_last   (rsp_frame_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   tfd_frame_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_class   (rsp_byte_class),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_last   (rsp_frame_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_gaps && !quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // offer one byte, with an optional gap before it, and wait for acceptance
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      @(negedge clock);
      if (send_gaps && !quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // drop valid and let every outstanding result drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // set the maximum length, then send random frames, noise and bad headers
   task automatic run_phase(input logic [LEN_W-1:0] max_len, input int n);
      int                stop_at;
      int                len;
      int                body;
      logic [BYTE_W-1:0] resv;
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= max_len;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      stop_at = sent + n;
      while (sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) begin
            send_gaps  = 1'($urandom_range(0, 1));
            stall_gaps = 1'($urandom_range(0, 1));
         end
         if ($urandom_range(0, 9) == 0) begin
            // line noise
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 5))
               0:       len = $urandom_range(0, 3);
               1:       len = int'(max_len);
               2:       len = (max_len < 16'hFFFF) ? int'(max_len) + 1 : $urandom_range(0, 3);
               3:       len = $urandom_range(0, 65535);
               default: len = $urandom_range(4, 40);
            endcase
            // keep accepted frames short so the run stays bounded
            if (len >= TPKT_HEADER_LEN && len <= max_len && len > CAP_LEN)
               len = $urandom_range(4, 40);
            resv = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                : TPKT_RESERVED;
            send_byte(TPKT_VERSION);
            send_byte(resv);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
            if (len >= TPKT_HEADER_LEN && len <= max_len) begin
               body = len - TPKT_HEADER_LEN;
               // now and then a truncated frame
               if ($urandom_range(0, 15) == 0)
                  body = $urandom_range(0, body);
               repeat (body) send_byte(BYTE_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed stream at the reset maximum
      foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

      // random phases: smallest, largest, below range, small and any maximum
      send_gaps  = 1'b1;
      stall_gaps = 1'b1;
      run_phase(16'd4, 200);
      run_phase(16'hFFFF, 300);
      run_phase(16'd0, 150);
      run_phase(LEN_W'($urandom_range(5, CAP_LEN)), 300);
      run_phase(LEN_W'($urandom_range(4, 65535)), 300);

      // closing stretch without idling
      quiet      = 1'b1;
      send_gaps  = 1'b0;
      stall_gaps = 1'b0;
      run_phase(MAX_LEN_RESET, 350);

      wait_idle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
